[rtl/s2c_pkg.sv]
// Shared constants, types and the Taylor divisor table for the point converter.
package s2c_pkg;

    // Default field widths.
    localparam int RANGE_BITS_DEF     = 18;
    localparam int ANGLE_BITS_DEF     = 16;
    localparam int TRIG_FRAC_BITS_DEF = 16;

    // Internal Q30 sine evaluation widths.
    localparam int Q_FRAC = 30;
    localparam int XR_W   = 31;
    localparam int X2_W   = 32;
    localparam int T_W    = 31;
    localparam int DIV_W  = 8;

    localparam logic [XR_W-1:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [T_W-1:0]  Q30_ONE     = 31'h4000_0000;

    // Pipeline shape.
    localparam int TAYLOR_STEPS  = 6;
    localparam int STEP_STAGES   = 3;
    localparam int SINE_STAGES   = 2 + TAYLOR_STEPS * STEP_STAGES + 2;
    localparam int SCALE_STAGES  = 4;
    localparam int PIPE_STAGES   = 1 + SINE_STAGES + SCALE_STAGES;

    // Sine lanes: cos(h), sin(h), cos(el), sin(el).
    localparam int LANE_CH = 0;
    localparam int LANE_SH = 1;
    localparam int LANE_CE = 2;
    localparam int LANE_SE = 3;
    localparam int LANES   = 4;

    // Sign of each trig factor, true when negative.
    typedef struct packed {
        logic ch;
        logic sh;
        logic ce;
        logic se;
    } t_sign;

    // Divisors of the Horner steps, innermost first.
    function automatic logic [DIV_W-1:0] taylor_div(input int step);
        logic [DIV_W-1:0] d;
        case (step)
            0: d = 8'd156;
            1: d = 8'd110;
            2: d = 8'd72;
            3: d = 8'd42;
            4: d = 8'd20;
            default: d = 8'd6;
        endcase
        return d;
    endfunction

endpackage

[rtl/s2c_sine.sv]
// Pipelined first-quadrant sine: Q30 Taylor series in Horner form, rounded.
module s2c_sine #(
    parameter int ANGLE_BITS     = s2c_pkg::ANGLE_BITS_DEF,
    parameter int TRIG_FRAC_BITS = s2c_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic [s2c_pkg::SINE_STAGES-1:0]   i_en,
    input  logic [ANGLE_BITS-2:0]             i_p,
    output logic [TRIG_FRAC_BITS:0]           o_mag
);
    localparam int QB     = ANGLE_BITS - 2;
    localparam int P_W    = ANGLE_BITS - 1;
    localparam int XRP_W  = s2c_pkg::XR_W + P_W;
    localparam int MAG_W  = TRIG_FRAC_BITS + 1;
    localparam int XR_W   = s2c_pkg::XR_W;
    localparam int X2_W   = s2c_pkg::X2_W;
    localparam int T_W    = s2c_pkg::T_W;
    localparam int NSTEP  = s2c_pkg::TAYLOR_STEPS;
    localparam int NSTAGE = s2c_pkg::SINE_STAGES;

    localparam logic [P_W-1:0]   QUARTER  = P_W'(1) << QB;
    localparam logic [31:0]      RND      = 32'(1) << (29 - TRIG_FRAC_BITS);
    localparam logic [MAG_W-1:0] TRIG_ONE = MAG_W'(1) << TRIG_FRAC_BITS;

    // Angle in radians, Q30; a full quarter turn is flagged as exactly one.
    logic [XR_W-1:0] r_xr0;
    logic            r_one0;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_xr0  <= XR_W'((XRP_W'(s2c_pkg::HALF_PI_Q30) * XRP_W'(i_p)) >> QB);
            r_one0 <= (i_p == QUARTER);
        end
    end

    // Square of the angle.
    logic [X2_W-1:0] r_x2_1;
    logic [XR_W-1:0] r_xr1;
    logic            r_one1;

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_x2_1 <= X2_W'((64'(r_xr0) * 64'(r_xr0)) >> s2c_pkg::Q_FRAC);
            r_xr1  <= r_xr0;
            r_one1 <= r_one0;
        end
    end

    // Values between Horner steps.
    logic [X2_W-1:0] w_x2  [0:NSTEP-1];
    logic [XR_W-1:0] w_xr  [0:NSTEP];
    logic            w_one [0:NSTEP];
    logic [T_W-1:0]  w_t   [0:NSTEP];

    assign w_x2[0]  = r_x2_1;
    assign w_xr[0]  = r_xr1;
    assign w_one[0] = r_one1;
    assign w_t[0]   = s2c_pkg::Q30_ONE;

    // Each step: t = 1 - floor(x2*t / d), three stages per step.
    for (genvar gs = 0; gs < NSTEP; gs++) begin : g_step
        localparam int BASE = 2 + gs * s2c_pkg::STEP_STAGES;
        localparam logic [s2c_pkg::DIV_W-1:0] DIV = s2c_pkg::taylor_div(gs);
        localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(DIV));

        logic [31:0]     r_prod_a;
        logic [XR_W-1:0] r_xr_a;
        logic            r_one_a;
        logic [31:0]     r_q0_b;
        logic [31:0]     r_prod_b;
        logic [XR_W-1:0] r_xr_b;
        logic            r_one_b;
        logic [31:0]     w_rem;
        logic [31:0]     w_quo;
        logic [T_W-1:0]  r_t_c;
        logic [XR_W-1:0] r_xr_c;
        logic            r_one_c;

        // Product with the running term.
        always_ff @(posedge i_clk) begin
            if (i_en[BASE]) begin
                r_prod_a <= 32'((64'(w_x2[gs]) * 64'(w_t[gs])) >> s2c_pkg::Q_FRAC);
                r_xr_a   <= w_xr[gs];
                r_one_a  <= w_one[gs];
            end
        end

        // Quotient estimate by reciprocal; it is exact or one short.
        always_ff @(posedge i_clk) begin
            if (i_en[BASE+1]) begin
                r_q0_b   <= 32'((64'(r_prod_a) * 64'(RECIP)) >> 32);
                r_prod_b <= r_prod_a;
                r_xr_b   <= r_xr_a;
                r_one_b  <= r_one_a;
            end
        end

        // Correct the estimate with the remainder.
        assign w_rem = r_prod_b - (r_q0_b * 32'(DIV));
        assign w_quo = r_q0_b + 32'(w_rem >= 32'(DIV));

        always_ff @(posedge i_clk) begin
            if (i_en[BASE+2]) begin
                r_t_c   <= T_W'(32'(s2c_pkg::Q30_ONE) - w_quo);
                r_xr_c  <= r_xr_b;
                r_one_c <= r_one_b;
            end
        end

        // The square rides along only as far as the last step that needs it.
        if (gs < NSTEP - 1) begin : g_x2
            logic [X2_W-1:0] r_x2_a;
            logic [X2_W-1:0] r_x2_b;
            logic [X2_W-1:0] r_x2_c;

            always_ff @(posedge i_clk) begin
                if (i_en[BASE]) begin
                    r_x2_a <= w_x2[gs];
                end
                if (i_en[BASE+1]) begin
                    r_x2_b <= r_x2_a;
                end
                if (i_en[BASE+2]) begin
                    r_x2_c <= r_x2_b;
                end
            end

            assign w_x2[gs+1] = r_x2_c;
        end

        assign w_xr[gs+1]  = r_xr_c;
        assign w_one[gs+1] = r_one_c;
        assign w_t[gs+1]   = r_t_c;
    end

    // Final product with the angle.
    logic [31:0] r_s;
    logic        r_one_f;
    logic [31:0] w_rnd;
    logic [MAG_W-1:0] r_mag;

    always_ff @(posedge i_clk) begin
        if (i_en[NSTAGE-2]) begin
            r_s     <= 32'((64'(w_xr[NSTEP]) * 64'(w_t[NSTEP])) >> s2c_pkg::Q_FRAC);
            r_one_f <= w_one[NSTEP];
        end
    end

    // Round to the output fraction and clamp at one.
    assign w_rnd = (r_s + RND) >> (s2c_pkg::Q_FRAC - TRIG_FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (i_en[NSTAGE-1]) begin
            if (r_one_f || (w_rnd > 32'(TRIG_ONE))) begin
                r_mag <= TRIG_ONE;
            end else begin
                r_mag <= MAG_W'(w_rnd);
            end
        end
    end

    assign o_mag = r_mag;

endmodule

[rtl/s2c_scale.sv]
// Trig products, range scaling, rounding and sign for the three coordinates.
module s2c_scale #(
    parameter int RANGE_BITS     = s2c_pkg::RANGE_BITS_DEF,
    parameter int TRIG_FRAC_BITS = s2c_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic [s2c_pkg::SCALE_STAGES-1:0]   i_en,
    input  logic [RANGE_BITS-1:0]              i_range,
    input  logic [TRIG_FRAC_BITS:0]            i_mag_ch,
    input  logic [TRIG_FRAC_BITS:0]            i_mag_sh,
    input  logic [TRIG_FRAC_BITS:0]            i_mag_ce,
    input  logic [TRIG_FRAC_BITS:0]            i_mag_se,
    input  s2c_pkg::t_sign                     i_sign,
    output logic signed [RANGE_BITS:0]         o_x_mm,
    output logic signed [RANGE_BITS:0]         o_y_mm,
    output logic signed [RANGE_BITS:0]         o_z_mm
);
    localparam int MAG_W = TRIG_FRAC_BITS + 1;
    localparam int PM_W  = 2 * MAG_W + 1;
    localparam int RP_W  = RANGE_BITS + MAG_W + 1;
    localparam int OUT_W = RANGE_BITS + 1;

    localparam logic [PM_W-1:0] HALF_M = PM_W'(1) << (TRIG_FRAC_BITS - 1);
    localparam logic [RP_W-1:0] HALF_R = RP_W'(1) << (TRIG_FRAC_BITS - 1);
    localparam logic [RP_W-1:0] R_MAX  = RP_W'({RANGE_BITS{1'b1}});

    // Round to whole millimeters, clamp to the range field, apply the sign.
    function automatic logic signed [OUT_W-1:0] to_out(input logic [RP_W-1:0] prod,
                                                       input logic neg);
        logic [RP_W-1:0]  mag;
        logic [OUT_W-1:0] m;
        mag = (prod + HALF_R) >> TRIG_FRAC_BITS;
        if (mag > R_MAX) begin
            mag = R_MAX;
        end
        m = OUT_W'(mag);
        return neg ? -m : m;
    endfunction

    // Products of the elevation and azimuth factors.
    logic [PM_W-1:0]       r_pc_full;
    logic [PM_W-1:0]       r_ps_full;
    logic [MAG_W-1:0]      r_se0;
    logic [RANGE_BITS-1:0] r_rng0;
    s2c_pkg::t_sign        r_sign0;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_pc_full <= PM_W'(i_mag_ce) * PM_W'(i_mag_ch);
            r_ps_full <= PM_W'(i_mag_ce) * PM_W'(i_mag_sh);
            r_se0     <= i_mag_se;
            r_rng0    <= i_range;
            r_sign0   <= i_sign;
        end
    end

    // Round the products back to trig precision; work out coordinate signs.
    logic [MAG_W-1:0]      r_pc;
    logic [MAG_W-1:0]      r_ps;
    logic [MAG_W-1:0]      r_se1;
    logic [RANGE_BITS-1:0] r_rng1;
    logic                  r_nx1;
    logic                  r_ny1;
    logic                  r_nz1;

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_pc   <= MAG_W'((r_pc_full + HALF_M) >> TRIG_FRAC_BITS);
            r_ps   <= MAG_W'((r_ps_full + HALF_M) >> TRIG_FRAC_BITS);
            r_se1  <= r_se0;
            r_rng1 <= r_rng0;
            r_nx1  <= r_sign0.ce ^ r_sign0.ch;
            r_ny1  <= r_sign0.ce ^ r_sign0.sh;
            r_nz1  <= r_sign0.se;
        end
    end

    // Scale by the range.
    logic [RP_W-1:0] r_px;
    logic [RP_W-1:0] r_py;
    logic [RP_W-1:0] r_pz;
    logic            r_nx2;
    logic            r_ny2;
    logic            r_nz2;

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_px  <= RP_W'(r_rng1) * RP_W'(r_pc);
            r_py  <= RP_W'(r_rng1) * RP_W'(r_ps);
            r_pz  <= RP_W'(r_rng1) * RP_W'(r_se1);
            r_nx2 <= r_nx1;
            r_ny2 <= r_ny1;
            r_nz2 <= r_nz1;
        end
    end

    // Output register.
    logic signed [OUT_W-1:0] r_x;
    logic signed [OUT_W-1:0] r_y;
    logic signed [OUT_W-1:0] r_z;

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_x <= to_out(r_px, r_nx2);
            r_y <= to_out(r_py, r_ny2);
            r_z <= to_out(r_pz, r_nz2);
        end
    end

    assign o_x_mm = r_x;
    assign o_y_mm = r_y;
    assign o_z_mm = r_z;

endmodule

[rtl/spherical_to_cartesian_point.sv]
// Top level: spherical scanner measurement to Cartesian point, fully pipelined.
//
// The input channel takes one word per accepted handshake: range in millimeters,
// azimuth and zenith as binary angles (a full turn is 2^ANGLE_BITS). The output
// channel delivers x, y and z in millimeters, two's complement, rounded.
// The datapath is 27 register stages: one input stage, 22 stages of four
// parallel sine units (a six-step Horner evaluation, three stages per step,
// with a multiplier in each), and 4 stages of products, scaling and sign.
// Throughput is one word per cycle while the receiver keeps taking words.
// Every stage holds its own valid bit.
// When the receiver stalls, the output register holds its word and stages fill
// from the back; the input is still accepted as long as any stage ahead of it
// is empty, so empty slots are squeezed out and nothing is lost or repeated.
// Reset (synchronous, active low) clears only the valid bits; the pipeline
// is empty and ready right after reset.
module spherical_to_cartesian_point #(
    parameter int RANGE_BITS     = s2c_pkg::RANGE_BITS_DEF,
    parameter int ANGLE_BITS     = s2c_pkg::ANGLE_BITS_DEF,
    parameter int TRIG_FRAC_BITS = s2c_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [RANGE_BITS-1:0]       i_range_mm,
    input  logic [ANGLE_BITS-1:0]       i_azimuth,
    input  logic [ANGLE_BITS-1:0]       i_zenith,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [RANGE_BITS:0]  o_x_mm,
    output logic signed [RANGE_BITS:0]  o_y_mm,
    output logic signed [RANGE_BITS:0]  o_z_mm
);
    localparam int NS    = s2c_pkg::PIPE_STAGES;
    localparam int SS    = s2c_pkg::SINE_STAGES;
    localparam int P_W   = ANGLE_BITS - 1;
    localparam int MAG_W = TRIG_FRAC_BITS + 1;

    localparam logic [ANGLE_BITS-1:0] QUARTER_A = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
    localparam logic [P_W-1:0]        QUARTER_P = P_W'(1) << (ANGLE_BITS - 2);

    // Valid bits and per-stage load enables.
    logic [NS-1:0] r_vld;
    logic [NS-1:0] n_vld;
    logic [NS-1:0] w_en;

    // A stage loads when some stage from it to the output is empty or the
    // output word is taken.
    for (genvar gk = 0; gk < NS; gk++) begin : g_en
        assign w_en[gk] = i_out_ready || !(&r_vld[NS-1:gk]);
    end

    always_comb begin
        n_vld[0] = w_en[0] ? i_in_valid : r_vld[0];
        for (int k = 1; k < NS; k++) begin
            n_vld[k] = w_en[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_vld[NS-1];

    // Input stage; elevation is zenith minus a quarter turn.
    logic [RANGE_BITS-1:0] r_rng0;
    logic [ANGLE_BITS-1:0] r_az0;
    logic [ANGLE_BITS-1:0] r_el0;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_rng0 <= i_range_mm;
            r_az0  <= i_azimuth;
            r_el0  <= i_zenith - QUARTER_A;
        end
    end

    // Angles of the four sines; cosine is the sine a quarter turn on.
    logic [ANGLE_BITS-1:0] w_ang [0:s2c_pkg::LANES-1];
    logic [MAG_W-1:0]      w_mag [0:s2c_pkg::LANES-1];
    logic [s2c_pkg::LANES-1:0] w_neg;

    assign w_ang[s2c_pkg::LANE_CH] = r_az0 + QUARTER_A;
    assign w_ang[s2c_pkg::LANE_SH] = r_az0;
    assign w_ang[s2c_pkg::LANE_CE] = r_el0 + QUARTER_A;
    assign w_ang[s2c_pkg::LANE_SE] = r_el0;

    // Fold each angle into the first quadrant and run a sine unit on it.
    for (genvar gl = 0; gl < s2c_pkg::LANES; gl++) begin : g_lane
        logic [1:0]     w_quad;
        logic [P_W-1:0] w_low;
        logic [P_W-1:0] w_p;

        assign w_quad    = w_ang[gl][ANGLE_BITS-1:ANGLE_BITS-2];
        assign w_low     = {1'b0, w_ang[gl][ANGLE_BITS-3:0]};
        assign w_p       = w_quad[0] ? (QUARTER_P - w_low) : w_low;
        assign w_neg[gl] = w_quad[1];

        s2c_sine #(
            .ANGLE_BITS     (ANGLE_BITS),
            .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
        ) u_sine (
            .i_clk (i_clk),
            .i_en  (w_en[SS:1]),
            .i_p   (w_p),
            .o_mag (w_mag[gl])
        );
    end

    s2c_pkg::t_sign w_sign0;

    assign w_sign0.ch = w_neg[s2c_pkg::LANE_CH];
    assign w_sign0.sh = w_neg[s2c_pkg::LANE_SH];
    assign w_sign0.ce = w_neg[s2c_pkg::LANE_CE];
    assign w_sign0.se = w_neg[s2c_pkg::LANE_SE];

    // Range and signs ride alongside the sine units.
    logic [RANGE_BITS-1:0] r_rng_d  [0:SS-1];
    s2c_pkg::t_sign        r_sign_d [0:SS-1];

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_rng_d[0]  <= r_rng0;
            r_sign_d[0] <= w_sign0;
        end
    end

    for (genvar gd = 1; gd < SS; gd++) begin : g_delay
        always_ff @(posedge i_clk) begin
            if (w_en[gd+1]) begin
                r_rng_d[gd]  <= r_rng_d[gd-1];
                r_sign_d[gd] <= r_sign_d[gd-1];
            end
        end
    end

    // Products, scaling and output register.
    s2c_scale #(
        .RANGE_BITS     (RANGE_BITS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_scale (
        .i_clk    (i_clk),
        .i_en     (w_en[NS-1:SS+1]),
        .i_range  (r_rng_d[SS-1]),
        .i_mag_ch (w_mag[s2c_pkg::LANE_CH]),
        .i_mag_sh (w_mag[s2c_pkg::LANE_SH]),
        .i_mag_ce (w_mag[s2c_pkg::LANE_CE]),
        .i_mag_se (w_mag[s2c_pkg::LANE_SE]),
        .i_sign   (r_sign_d[SS-1]),
        .o_x_mm   (o_x_mm),
        .o_y_mm   (o_y_mm),
        .o_z_mm   (o_z_mm)
    );

endmodule

[sim/point_check.sv]
`timescale 1ns / 1ps
// Point checker: predicts each converted point and compares it with the block output.
module point_check #(
    parameter int RB = s2c_pkg::RANGE_BITS_DEF,
    parameter int AB = s2c_pkg::ANGLE_BITS_DEF,
    parameter int TF = s2c_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [RB-1:0]        i_range_mm,
    input  logic [AB-1:0]        i_azimuth,
    input  logic [AB-1:0]        i_zenith,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic signed [RB:0]   i_x_mm,
    input  logic signed [RB:0]   i_y_mm,
    input  logic signed [RB:0]   i_z_mm,
    output int                   o_mismatches,
    output int                   o_pending,
    output int                   o_checked
);

    // Fixed-point constants of the sine evaluation and the scaling.
    localparam logic [63:0] Q30_ONE   = 64'd1 << 30;
    localparam logic [63:0] HALF_PI   = 64'(s2c_pkg::HALF_PI_Q30);
    localparam logic [63:0] QUARTER   = 64'd1 << (AB - 2);
    localparam logic [63:0] TRIG_ONE  = 64'd1 << TF;
    localparam logic [63:0] TRIG_HALF = 64'd1 << (TF - 1);
    localparam logic [63:0] RANGE_MAX = (64'd1 << RB) - 64'd1;
    localparam logic [AB-1:0] QUARTER_TURN = AB'(1) << (AB - 2);

    // Horner divisors, innermost step in the lowest byte.
    localparam logic [5:0][7:0] HORNER_DIV = {8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156};

    typedef struct packed {
        logic signed [RB:0] x;
        logic signed [RB:0] y;
        logic signed [RB:0] z;
    } t_point;

    t_point expected_points[$];
    int     mismatch_count = 0;
    int     checked_count  = 0;

    // Sine magnitude of a first-quadrant angle, TF fraction bits.
    function automatic logic [63:0] quadrant_sine(input logic [63:0] p);
        logic [63:0] xr, x2, t, s;
        int          k;
        if (p >= QUARTER) begin
            return TRIG_ONE;
        end
        xr = (HALF_PI * p) >> (AB - 2);
        x2 = (xr * xr) >> 30;
        t  = Q30_ONE;
        for (k = 0; k < 6; k++) begin
            t = Q30_ONE - ((x2 * t) >> 30) / 64'(HORNER_DIV[k]);
        end
        s = (xr * t) >> 30;
        s = (s + (64'd1 << (29 - TF))) >> (30 - TF);
        if (s > TRIG_ONE) begin
            s = TRIG_ONE;
        end
        return s;
    endfunction

    // Sine of a full binary angle, split into magnitude and sign.
    function automatic void angle_sine(input logic [AB-1:0] a, output logic [63:0] mag,
                                       output logic neg);
        logic [1:0]  quad;
        logic [63:0] p;
        quad = a[AB-1:AB-2];
        p    = 64'(a[AB-3:0]);
        if (quad[0]) begin
            p = QUARTER - p;
        end
        mag = quadrant_sine(p);
        neg = quad[1];
    endfunction

    // Magnitude and sign to a two's complement coordinate; zero stays zero.
    function automatic logic signed [RB:0] signed_coord(input logic [63:0] mag,
                                                        input logic neg);
        logic [63:0]        m;
        logic signed [RB:0] c;
        m = (mag > RANGE_MAX) ? RANGE_MAX : mag;
        c = m[RB:0];
        if (neg) begin
            c = -c;
        end
        return c;
    endfunction

    // Full conversion of one measurement into the point the block should deliver.
    function automatic t_point predict_point(input logic [RB-1:0] r, input logic [AB-1:0] az,
                                             input logic [AB-1:0] zen);
        logic [AB-1:0] el, az_cos, el_cos;
        logic [63:0]   ch, sh, ce, se, pc, ps, r64;
        logic          nch, nsh, nce, nse;
        t_point        pt;
        el     = zen - QUARTER_TURN;
        az_cos = az + QUARTER_TURN;
        el_cos = el + QUARTER_TURN;
        angle_sine(az_cos, ch, nch);
        angle_sine(az, sh, nsh);
        angle_sine(el_cos, ce, nce);
        angle_sine(el, se, nse);
        pc   = (ce * ch + TRIG_HALF) >> TF;
        ps   = (ce * sh + TRIG_HALF) >> TF;
        r64  = 64'(r);
        pt.x = signed_coord((r64 * pc + TRIG_HALF) >> TF, nce ^ nch);
        pt.y = signed_coord((r64 * ps + TRIG_HALF) >> TF, nce ^ nsh);
        pt.z = signed_coord((r64 * se + TRIG_HALF) >> TF, nse);
        return pt;
    endfunction

    // Compare each delivered word with the oldest prediction, then queue new ones.
    always @(posedge i_clk) begin : watch
        t_point got, want;
        if (i_rst_n && i_out_valid && i_out_ready) begin
            got.x = i_x_mm;
            got.y = i_y_mm;
            got.z = i_z_mm;
            if (expected_points.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("%0t: unexpected word x=%0d y=%0d z=%0d",
                             $realtime, got.x, got.y, got.z);
                end
            end else begin
                want = expected_points.pop_front();
                checked_count++;
                if (got.x != want.x || got.y != want.y || got.z != want.z) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("%0t: mismatch exp (%0d, %0d, %0d) got (%0d, %0d, %0d)",
                                 $realtime, want.x, want.y, want.z, got.x, got.y, got.z);
                    end
                end
            end
        end
        if (i_rst_n && i_in_valid && i_in_ready) begin
            expected_points.push_back(predict_point(i_range_mm, i_azimuth, i_zenith));
        end
        o_mismatches <= mismatch_count;
        o_pending    <= expected_points.size();
        o_checked    <= checked_count;
    end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// Testbench top: drives measurements into the point converter and gives the verdict.
module testbench;

    localparam int RB = s2c_pkg::RANGE_BITS_DEF;
    localparam int AB = s2c_pkg::ANGLE_BITS_DEF;
    localparam int TF = s2c_pkg::TRIG_FRAC_BITS_DEF;

    localparam logic [RB-1:0] RANGE_MAX    = '1;
    localparam int            HOLD_CYCLES  = 300;
    localparam int            MAX_GAP      = 60;
    localparam int            DRAIN_CYCLES = 40;
    localparam int            TIMEOUT_NS   = 2_000_000;

    typedef enum logic [0:0] {RX_RANDOM, RX_HOLD} t_rx_mode;

    logic                i_clk;
    logic                i_rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [RB-1:0]       range_mm;
    logic [AB-1:0]       azimuth;
    logic [AB-1:0]       zenith;
    logic                out_valid;
    logic                out_ready;
    logic signed [RB:0]  x_mm;
    logic signed [RB:0]  y_mm;
    logic signed [RB:0]  z_mm;

    int       tx_idle_pct  = 0;
    int       rx_stall_pct = 0;
    t_rx_mode rx_mode      = RX_RANDOM;
    int       hold_count   = 0;
    int       points_sent  = 0;
    int       mismatches;
    int       pending;
    int       checked;

    spherical_to_cartesian_point u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_range_mm  (range_mm),
        .i_azimuth   (azimuth),
        .i_zenith    (zenith),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_x_mm      (x_mm),
        .o_y_mm      (y_mm),
        .o_z_mm      (z_mm)
    );

    point_check #(.RB(RB), .AB(AB), .TF(TF)) u_point_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_range_mm   (range_mm),
        .i_azimuth    (azimuth),
        .i_zenith     (zenith),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_x_mm       (x_mm),
        .i_y_mm       (y_mm),
        .i_z_mm       (z_mm),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs or loses a word.
    initial begin
        #(TIMEOUT_NS);
        $display("testbench: FAIL");
        $finish;
    end

    // Receiver: random stalls, or one long hold-off counted here.
    initial begin
        out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_mode == RX_HOLD) begin
                if (hold_count < HOLD_CYCLES) begin
                    out_ready <= 1'b0;
                    hold_count++;
                end else begin
                    out_ready <= 1'b1;
                end
            end else begin
                hold_count = 0;
                out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    // Offer one word after an optional idle gap and wait until it is taken.
    task automatic send_point(input logic [RB-1:0] r, input logic [AB-1:0] az,
                              input logic [AB-1:0] zen);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < tx_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        range_mm <= r;
        azimuth  <= az;
        zenith   <= zen;
        do @(posedge i_clk); while (!in_ready);
        points_sent++;
    endtask

    // Random angle, leaning on quadrant boundaries now and then.
    function automatic logic [AB-1:0] random_angle();
        logic [AB-1:0] a;
        if ($urandom_range(0, 9) < 2) begin
            a = (AB'($urandom_range(0, 3)) << (AB - 2)) + AB'($urandom_range(0, 2)) - AB'(1);
        end else begin
            a = AB'($urandom);
        end
        return a;
    endfunction

    // One random measurement with a mix of full, tiny and extreme ranges.
    task automatic send_random_point();
        logic [RB-1:0] r;
        case ($urandom_range(0, 9))
            0: r = RANGE_MAX;
            1: r = RB'($urandom_range(0, 15));
            2: r = '0;
            default: r = RB'($urandom);
        endcase
        send_point(r, random_angle(), random_angle());
    endtask

    // Stop offering and wait until every predicted point has come out.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // One phase of random traffic under the given idle and stall rates.
    task automatic run_phase(input int count, input int tx_pct, input int rx_pct,
                             input t_rx_mode mode);
        tx_idle_pct = tx_pct;
        rx_stall_pct <= rx_pct;
        rx_mode      <= mode;
        repeat (count) send_random_point();
        wait_for_drain();
    endtask

    // Stimulus and verdict.
    initial begin
        i_rst_n  = 1'b0;
        in_valid = 1'b0;
        range_mm = '0;
        azimuth  = '0;
        zenith   = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero and full range, quadrant edges, poles, zero coordinates
        // with a negative factor, and tiny ranges that round to zero.
        send_point('0, 16'h0000, 16'h0000);
        send_point(RANGE_MAX, 16'h0000, 16'h4000);
        send_point(RANGE_MAX, 16'h4000, 16'h4000);
        send_point(RANGE_MAX, 16'h8000, 16'h4000);
        send_point(RANGE_MAX, 16'hC000, 16'h4000);
        send_point(RANGE_MAX, 16'hFFFF, 16'h4000);
        send_point(RANGE_MAX, 16'h2000, 16'h0000);
        send_point(RANGE_MAX, 16'h2000, 16'h8000);
        send_point(RANGE_MAX, 16'h6000, 16'hC000);
        send_point(RANGE_MAX, 16'hA000, 16'hFFFF);
        send_point(RANGE_MAX, 16'h3FFF, 16'h0001);
        send_point(RANGE_MAX, 16'h4001, 16'h7FFF);
        send_point(18'd1, 16'h8001, 16'h4000);
        send_point(18'd1, 16'h2AAA, 16'h5555);
        send_point(18'd2, 16'hD555, 16'h3000);
        send_point(RANGE_MAX, 16'h5555, 16'hAAAA);
        send_point(18'h2AAAA, 16'hAAAA, 16'h5555);
        send_point(18'h15555, 16'h5555, 16'hAAAA);
        send_point(RANGE_MAX, 16'h0001, 16'h4001);
        send_point('0, 16'hFFFF, 16'hFFFF);
        wait_for_drain();

        // Random phases: no idling, sender gaps, receiver stalls, light mix.
        run_phase(350, 0, 0, RX_RANDOM);
        run_phase(300, 82, 0, RX_RANDOM);
        run_phase(300, 0, 82, RX_RANDOM);
        run_phase(300, 6, 6, RX_RANDOM);

        // Long receiver hold-off while words keep coming, so the input backs up.
        run_phase(250, 0, 0, RX_HOLD);

        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d words: directed extremes and quadrant edges, then random",
                 points_sent);
        $display("traffic with gaps, stalls and a %0d-cycle hold; %0d results checked.",
                 HOLD_CYCLES, checked);
        if (mismatches == 0 && pending == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
